[hw/rtl/cwd_pkg.sv]
// cwd_pkg: shared types, constants and micro-op tables of the calibration weight
// derivative core. No dependencies; every other file depends on it.
package cwd_pkg;

  localparam int DW        = 32;   // Q16.16 field width
  localparam int OPW       = 33;   // multiplier operand width (signed)
  localparam int PW        = 66;   // multiplier product width
  localparam int AW        = 64;   // accumulator width
  localparam int NW        = 130;  // wide accumulator for a*b - c*d and b*b
  localparam int MAG_W     = 128;  // magnitude of the wide values
  localparam int NUM_W     = 146;  // dividend: |N| << 17 plus b*b
  localparam int DEN_W     = 128;  // divisor: 2*b*b
  localparam int DIV_CNT_W = 8;
  localparam int STEP_W    = 5;
  localparam int ITEM_LAST = 31;
  localparam int FIN_LAST  = 12;
  localparam int TV_N      = 12;   // t2/t4/t5 parts plus six weighted terms
  localparam int TERM_BASE = 6;
  localparam int N_ACC     = 6;
  localparam int CFG_IDX_W = 1;

  typedef logic signed [DW-1:0]  q16_t;
  typedef logic signed [AW-1:0]  acc_t;
  typedef logic signed [NW-1:0]  wide_t;
  typedef logic signed [OPW-1:0] opnd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEIGHT_RE,
    REG_WEIGHT_IM
  } reg_idx_t;

  // accumulator slots
  localparam logic [2:0] ACC_A_RE = 3'd0;
  localparam logic [2:0] ACC_A_IM = 3'd1;
  localparam logic [2:0] ACC_B    = 3'd2;
  localparam logic [2:0] ACC_C_RE = 3'd3;
  localparam logic [2:0] ACC_C_IM = 3'd4;
  localparam logic [2:0] ACC_D    = 3'd5;

  typedef enum logic [4:0] {
    SRC_ZERO, SRC_CAL_RE, SRC_CAL_IM, SRC_W_RE, SRC_W_IM,
    SRC_Y_RE, SRC_Y_IM, SRC_F_RE, SRC_F_IM, SRC_A_RE, SRC_A_IM,
    SRC_T2R, SRC_T2I, SRC_T4R, SRC_T4I, SRC_T5R, SRC_T5I,
    SRC_TERM, SRC_LAM,
    SRC_AH, SRC_AL, SRC_BH, SRC_BL, SRC_CH, SRC_CL, SRC_DH, SRC_DL
  } src_t;

  typedef enum logic [2:0] {
    ACT_NONE,    // nothing
    ACT_LOAD,    // first product of a dot
    ACT_ADD_ST,  // add second product, round, store
    ACT_SUB_ST,  // subtract second product, round, store
    ACT_WACC,    // weight by lambda, saturating accumulate
    ACT_NADD,    // wide numerator add
    ACT_NSUB,    // wide numerator subtract
    ACT_BBADD    // wide b*b add
  } act_t;

  typedef struct packed {
    src_t        a;
    src_t        b;
    act_t        act;
    logic [3:0]  idx;  // store slot / term / accumulator
    logic [1:0]  sh;   // dot: 1 = doubled (shift 15); wide: limb shift 0/32/64
  } uop_t;

  localparam uop_t UOP_NOP = '{a: SRC_ZERO, b: SRC_ZERO, act: ACT_NONE, idx: 4'd0, sh: 2'd0};

  function automatic uop_t mk(src_t a, src_t b, act_t act, logic [3:0] idx,
                              logic [1:0] sh);
    uop_t u;
    u.a = a; u.b = b; u.act = act; u.idx = idx; u.sh = sh;
    return u;
  endfunction

  // Per-measurement program. Store slots: 0..5 = t2r,t2i,t4r,t4i,t5r,t5i,
  // 6..11 = weighted-term inputs in accumulator order.
  function automatic uop_t item_uop(logic [STEP_W-1:0] s);
    uop_t u;
    unique case (s)
      5'd0:  u = mk(SRC_CAL_RE, SRC_W_RE, ACT_LOAD,   4'd0,  2'd0);
      5'd1:  u = mk(SRC_CAL_IM, SRC_W_IM, ACT_SUB_ST, 4'd0,  2'd0);
      5'd2:  u = mk(SRC_CAL_RE, SRC_W_IM, ACT_LOAD,   4'd0,  2'd0);
      5'd3:  u = mk(SRC_CAL_IM, SRC_W_RE, ACT_ADD_ST, 4'd1,  2'd0);
      5'd5:  u = mk(SRC_T2R,    SRC_F_RE, ACT_LOAD,   4'd0,  2'd0);
      5'd6:  u = mk(SRC_T2I,    SRC_F_IM, ACT_SUB_ST, 4'd2,  2'd0);
      5'd7:  u = mk(SRC_T2R,    SRC_F_IM, ACT_LOAD,   4'd0,  2'd0);
      5'd8:  u = mk(SRC_T2I,    SRC_F_RE, ACT_ADD_ST, 4'd3,  2'd0);
      5'd9:  u = mk(SRC_T2R,    SRC_A_RE, ACT_LOAD,   4'd0,  2'd0);
      5'd10: u = mk(SRC_T2I,    SRC_A_IM, ACT_SUB_ST, 4'd4,  2'd0);
      5'd11: u = mk(SRC_T2R,    SRC_A_IM, ACT_LOAD,   4'd0,  2'd0);
      5'd12: u = mk(SRC_T2I,    SRC_A_RE, ACT_ADD_ST, 4'd5,  2'd0);
      5'd13: u = mk(SRC_Y_RE,   SRC_T4R,  ACT_LOAD,   4'd0,  2'd0);
      5'd14: u = mk(SRC_Y_IM,   SRC_T4I,  ACT_ADD_ST, 4'd9,  2'd0);
      5'd15: u = mk(SRC_Y_IM,   SRC_T4R,  ACT_LOAD,   4'd0,  2'd0);
      5'd16: u = mk(SRC_Y_RE,   SRC_T4I,  ACT_SUB_ST, 4'd10, 2'd0);
      5'd17: u = mk(SRC_T4R,    SRC_T4R,  ACT_LOAD,   4'd0,  2'd0);
      5'd18: u = mk(SRC_T4I,    SRC_T4I,  ACT_ADD_ST, 4'd8,  2'd0);
      5'd19: u = mk(SRC_Y_RE,   SRC_T5R,  ACT_LOAD,   4'd0,  2'd0);
      5'd20: u = mk(SRC_Y_IM,   SRC_T5I,  ACT_ADD_ST, 4'd6,  2'd0);
      5'd21: u = mk(SRC_Y_IM,   SRC_T5R,  ACT_LOAD,   4'd0,  2'd0);
      5'd22: u = mk(SRC_Y_RE,   SRC_T5I,  ACT_SUB_ST, 4'd7,  2'd0);
      5'd23: u = mk(SRC_T4R,    SRC_T5R,  ACT_LOAD,   4'd0,  2'd0);
      5'd24: u = mk(SRC_T4I,    SRC_T5I,  ACT_ADD_ST, 4'd11, 2'd1);
      5'd25: u = mk(SRC_TERM,   SRC_LAM,  ACT_WACC,   4'd0,  2'd0);
      5'd26: u = mk(SRC_TERM,   SRC_LAM,  ACT_WACC,   4'd1,  2'd0);
      5'd27: u = mk(SRC_TERM,   SRC_LAM,  ACT_WACC,   4'd2,  2'd0);
      5'd28: u = mk(SRC_TERM,   SRC_LAM,  ACT_WACC,   4'd3,  2'd0);
      5'd29: u = mk(SRC_TERM,   SRC_LAM,  ACT_WACC,   4'd4,  2'd0);
      5'd30: u = mk(SRC_TERM,   SRC_LAM,  ACT_WACC,   4'd5,  2'd0);
      default: u = UOP_NOP;  // t2 settle bubble and final drain
    endcase
    return u;
  endfunction

  // Group-end program: b*b, then a*b - c*d, from 32-bit limbs.
  function automatic uop_t fin_uop(logic [3:0] s);
    uop_t u;
    unique case (s)
      4'd0:  u = mk(SRC_BH, SRC_BH, ACT_BBADD, 4'd0, 2'd2);
      4'd1:  u = mk(SRC_BH, SRC_BL, ACT_BBADD, 4'd0, 2'd1);
      4'd2:  u = mk(SRC_BL, SRC_BH, ACT_BBADD, 4'd0, 2'd1);
      4'd3:  u = mk(SRC_BL, SRC_BL, ACT_BBADD, 4'd0, 2'd0);
      4'd4:  u = mk(SRC_AH, SRC_BH, ACT_NADD,  4'd0, 2'd2);
      4'd5:  u = mk(SRC_AH, SRC_BL, ACT_NADD,  4'd0, 2'd1);
      4'd6:  u = mk(SRC_AL, SRC_BH, ACT_NADD,  4'd0, 2'd1);
      4'd7:  u = mk(SRC_AL, SRC_BL, ACT_NADD,  4'd0, 2'd0);
      4'd8:  u = mk(SRC_CH, SRC_DH, ACT_NSUB,  4'd0, 2'd2);
      4'd9:  u = mk(SRC_CH, SRC_DL, ACT_NSUB,  4'd0, 2'd1);
      4'd10: u = mk(SRC_CL, SRC_DH, ACT_NSUB,  4'd0, 2'd1);
      4'd11: u = mk(SRC_CL, SRC_DL, ACT_NSUB,  4'd0, 2'd0);
      default: u = UOP_NOP;
    endcase
    return u;
  endfunction

endpackage

[hw/rtl/cwd_if.sv]
// cwd_in_if / cwd_out_if: valid/ready request channels of the core.
// Depends on cwd_pkg for field types.
interface cwd_in_if;
  logic                valid;
  logic                ready;
  cwd_pkg::q16_t       meas_re;
  cwd_pkg::q16_t       meas_im;
  cwd_pkg::q16_t       fwd_re;
  cwd_pkg::q16_t       fwd_im;
  cwd_pkg::q16_t       col_re;
  cwd_pkg::q16_t       col_im;
  logic [31:0]         noise_weight;
  cwd_pkg::q16_t       cal_re;
  cwd_pkg::q16_t       cal_im;
  logic                last_item;

  modport source (output valid, meas_re, meas_im, fwd_re, fwd_im, col_re, col_im,
                  noise_weight, cal_re, cal_im, last_item, input ready);
  modport sink   (input valid, meas_re, meas_im, fwd_re, fwd_im, col_re, col_im,
                  noise_weight, cal_re, cal_im, last_item, output ready);
endinterface

interface cwd_out_if;
  logic          valid;
  logic          ready;
  cwd_pkg::q16_t deriv_re;
  cwd_pkg::q16_t deriv_im;
  logic          zero_energy;

  modport source (output valid, deriv_re, deriv_im, zero_energy, input ready);
  modport sink   (input valid, deriv_re, deriv_im, zero_energy, output ready);
endinterface

[hw/rtl/cwd_mul.sv]
// cwd_mul: the shared 33x33 signed multiplier, product registered.
// Depends on cwd_pkg.
module cwd_mul (
  input  logic                           clk,
  input  logic signed [cwd_pkg::OPW-1:0] a,
  input  logic signed [cwd_pkg::OPW-1:0] b,
  output logic signed [cwd_pkg::PW-1:0]  p
);
  import cwd_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

[hw/rtl/cwd_div.sv]
// cwd_div: restoring divider, one quotient bit per cycle, keeps the low 32
// quotient bits plus an overflow flag. Depends on cwd_pkg.
module cwd_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cwd_pkg::NUM_W-1:0]  num,
  input  logic [cwd_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [cwd_pkg::DW-1:0]     quot,
  output logic                       big
);
  import cwd_pkg::*;

  logic                 run;
  logic [DIV_CNT_W-1:0] cnt;
  logic [NUM_W-1:0]     nsh;
  logic [DEN_W-1:0]     dreg;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     shifted;
  logic                 ge;

  // rem stays below den <= 2^127, so its top bit is always clear
  assign shifted = {rem[DEN_W-2:0], nsh[NUM_W-1]};
  assign ge      = shifted >= dreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= DIV_CNT_W'(NUM_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh  <= num;
      dreg <= den;
      rem  <= '0;
      quot <= '0;
      big  <= 1'b0;
    end else if (run) begin
      nsh  <= {nsh[NUM_W-2:0], 1'b0};
      rem  <= ge ? shifted - dreg : shifted;
      quot <= {quot[DW-2:0], ge};
      big  <= big | quot[DW-1];
    end
  end
endmodule

[hw/rtl/calibration_weight_derivative_core.sv]
// calibration_weight_derivative_core: top level, sequencer and datapath.
// Depends on cwd_pkg, cwd_if, cwd_mul, cwd_div.
//
// Each measurement request runs, from acceptance to the next ready, through
// 31 issue slots of one shared 33x33 multiplier (24 complex-product terms, a
// wait slot for t2, six lambda weightings), a drain slot and a check.
// in_chan.ready is high only while the core is idle. The request flagged
// last_item then runs the group finish: per real/imaginary part, 12 limb
// products on the same multiplier build b*b and a*b - c*d in 130-bit
// registers, and a restoring divider computes the rounded quotient. A zero b
// skips the finish and returns a zero result with zero_energy set. The result
// sits in its output register on out_chan until taken; measurements keep
// flowing meanwhile, and only the next group end waits in its check cycle for
// that register to empty. The user must write the weight registers through
// cfg_we/cfg_index/cfg_data only while the core is idle; the block itself
// does not enforce it.
module calibration_weight_derivative_core (
  input  logic                              clk,
  input  logic                              rst,
  cwd_in_if.sink                            in_chan,
  cwd_out_if.source                         out_chan,
  input  logic                              cfg_we,
  input  logic [cwd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cwd_pkg::DW-1:0]            cfg_data
);
  import cwd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ITEM, S_CHECK, S_FIN, S_DSTART, S_DWAIT
  } state_t;

  state_t              state;
  logic [STEP_W-1:0]   step;
  logic                comp;      // 0: real part, 1: imaginary part
  logic                in_fire;

  // configuration
  q16_t weight_re, weight_im;

  // captured request
  q16_t y_re, y_im, f_re, f_im, c_re, c_im, k_re, k_im;
  logic [DW-1:0] lam;
  logic          last_r;

  // datapath
  uop_t               uop, uop_d;
  opnd_t              opa, opb;
  logic signed [PW-1:0] prod;
  logic signed [64:0] dacc;
  q16_t               tv [TV_N];
  acc_t               acc [N_ACC];
  wide_t              nacc, bb;
  logic               acc_clr, fin_clr;

  // results (output register)
  q16_t res_re, res_im;
  logic zflag;
  logic ovalid;
  logic sn_r;

  // divider
  logic                div_start, div_done, div_big;
  logic [DW-1:0]       div_q;
  logic [MAG_W-1:0]    nmag;
  logic [NUM_W-1:0]    div_num;
  logic [DEN_W-1:0]    div_den;
  q16_t                sres;

  assign in_fire          = in_chan.valid && in_chan.ready;
  assign in_chan.ready    = (state == S_IDLE);
  assign out_chan.valid   = ovalid;
  assign out_chan.deriv_re    = res_re;
  assign out_chan.deriv_im    = res_im;
  assign out_chan.zero_energy = zflag;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_re <= 32'sh0001_0000;
      weight_im <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WEIGHT_RE: weight_re <= cfg_data;
        REG_WEIGHT_IM: weight_im <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- request capture ----------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      y_re   <= in_chan.meas_re;
      y_im   <= in_chan.meas_im;
      f_re   <= in_chan.fwd_re;
      f_im   <= in_chan.fwd_im;
      c_re   <= in_chan.col_re;
      c_im   <= in_chan.col_im;
      lam    <= in_chan.noise_weight;
      k_re   <= in_chan.cal_re;
      k_im   <= in_chan.cal_im;
      last_r <= in_chan.last_item;
    end
  end

  // ---------------- micro-op issue ----------------
  always_comb begin
    if (state == S_ITEM)     uop = item_uop(step);
    else if (state == S_FIN) uop = fin_uop(step[3:0]);
    else                     uop = UOP_NOP;
  end

  // operand fetch; wide values split into a signed high and unsigned low limb
  function automatic opnd_t src_val(src_t s);
    opnd_t v;
    acc_t  av, cv;
    av = comp ? acc[ACC_A_IM] : acc[ACC_A_RE];
    cv = comp ? acc[ACC_C_IM] : acc[ACC_C_RE];
    unique case (s)
      SRC_ZERO:   v = '0;
      SRC_CAL_RE: v = OPW'(k_re);
      SRC_CAL_IM: v = OPW'(k_im);
      SRC_W_RE:   v = OPW'(weight_re);
      SRC_W_IM:   v = OPW'(weight_im);
      SRC_Y_RE:   v = OPW'(y_re);
      SRC_Y_IM:   v = OPW'(y_im);
      SRC_F_RE:   v = OPW'(f_re);
      SRC_F_IM:   v = OPW'(f_im);
      SRC_A_RE:   v = OPW'(c_re);
      SRC_A_IM:   v = OPW'(c_im);
      SRC_T2R:    v = OPW'(tv[0]);
      SRC_T2I:    v = OPW'(tv[1]);
      SRC_T4R:    v = OPW'(tv[2]);
      SRC_T4I:    v = OPW'(tv[3]);
      SRC_T5R:    v = OPW'(tv[4]);
      SRC_T5I:    v = OPW'(tv[5]);
      SRC_TERM:   v = OPW'(tv[4'(TERM_BASE) + uop.idx]);
      SRC_LAM:    v = {1'b0, lam};
      SRC_AH:     v = {av[AW-1], av[AW-1:DW]};
      SRC_AL:     v = {1'b0, av[DW-1:0]};
      SRC_BH:     v = {acc[ACC_B][AW-1], acc[ACC_B][AW-1:DW]};
      SRC_BL:     v = {1'b0, acc[ACC_B][DW-1:0]};
      SRC_CH:     v = {cv[AW-1], cv[AW-1:DW]};
      SRC_CL:     v = {1'b0, cv[DW-1:0]};
      SRC_DH:     v = {acc[ACC_D][AW-1], acc[ACC_D][AW-1:DW]};
      SRC_DL:     v = {1'b0, acc[ACC_D][DW-1:0]};
      default:    v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    opa = src_val(uop.a);
    opb = src_val(uop.b);
  end

  cwd_mul u_mul (.clk(clk), .a(opa), .b(opb), .p(prod));

  // ---------------- product consumption ----------------
  logic signed [66:0] dsum, dround;
  q16_t               dot_res;
  logic signed [PW-1:0] wsc;
  logic signed [AW:0]   asum;
  acc_t                 acc_new;
  wide_t                pwide, pshift;

  always_comb begin
    // dot: exact sum of two products, round half up, saturate
    if (uop_d.act == ACT_SUB_ST) dsum = 67'(dacc) - 67'(prod);
    else                         dsum = 67'(dacc) + 67'(prod);
    if (uop_d.sh[0]) dround = (dsum + 67'sd16384) >>> 15;  // doubled term
    else             dround = (dsum + 67'sd32768) >>> 16;
    if (dround > 67'sd2147483647)       dot_res = 32'sh7FFF_FFFF;
    else if (dround < -67'sd2147483648) dot_res = 32'sh8000_0000;
    else                                dot_res = dround[DW-1:0];

    // lambda weighting and saturating accumulate
    wsc  = (prod + 66'sd32768) >>> 16;
    asum = (AW+1)'(acc[uop_d.idx[2:0]]) + (AW+1)'(wsc);
    if (asum[AW] != asum[AW-1]) acc_new = asum[AW] ? {1'b1, {(AW-1){1'b0}}}
                                                   : {1'b0, {(AW-1){1'b1}}};
    else                        acc_new = asum[AW-1:0];

    // limb product placed at its weight
    pwide = NW'(prod);
    unique case (uop_d.sh)
      2'd1:    pshift = pwide <<< 32;
      2'd2:    pshift = pwide <<< 64;
      default: pshift = pwide;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) uop_d <= UOP_NOP;
    else     uop_d <= uop;
  end

  always_ff @(posedge clk) begin
    unique case (uop_d.act)
      ACT_LOAD:   dacc <= prod[64:0];
      ACT_ADD_ST,
      ACT_SUB_ST: tv[uop_d.idx] <= dot_res;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fin_clr) begin
      nacc <= '0;
      bb   <= '0;
    end else begin
      unique case (uop_d.act)
        ACT_NADD:  nacc <= nacc + pshift;
        ACT_NSUB:  nacc <= nacc - pshift;
        ACT_BBADD: bb   <= bb + pshift;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || acc_clr) begin
      for (int i = 0; i < N_ACC; i++) acc[i] <= '0;
    end else if (uop_d.act == ACT_WACC) begin
      acc[uop_d.idx[2:0]] <= acc_new;
    end
  end

  // ---------------- group finish: divide ----------------
  // q = round(|N| * 2^16 / bb), ties away from zero: (|N|<<17 + bb) / (2 bb)
  assign nmag      = nacc[NW-1] ? MAG_W'(-nacc) : nacc[MAG_W-1:0];
  assign div_num   = NUM_W'({nmag, 17'd0}) + NUM_W'(bb[MAG_W-1:0]);
  assign div_den   = {bb[DEN_W-2:0], 1'b0};
  assign div_start = (state == S_DSTART);

  cwd_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_q), .big(div_big)
  );

  always_comb begin
    if (sn_r) begin
      if (div_big || div_q > 32'h8000_0000) sres = 32'sh8000_0000;
      else                                  sres = -div_q;
    end else begin
      if (div_big || div_q[DW-1])           sres = 32'sh7FFF_FFFF;
      else                                  sres = div_q;
    end
  end

  // sums clear after the group result; wide regs clear before each part
  assign acc_clr = (state == S_CHECK && last_r && !ovalid && acc[ACC_B] == '0) ||
                   (state == S_DWAIT && div_done && comp);
  assign fin_clr = (state == S_CHECK && last_r && !ovalid) ||
                   (state == S_DWAIT && div_done && !comp);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      step   <= '0;
      comp   <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      // output register empties on its handshake; it is only refilled while empty
      if (ovalid && out_chan.ready) ovalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= S_ITEM;
            step  <= '0;
          end
        end
        S_ITEM: begin
          if (step == STEP_W'(ITEM_LAST)) state <= S_CHECK;
          else                            step  <= step + 1'b1;
        end
        S_CHECK: begin
          if (!last_r) begin
            state <= S_IDLE;
          end else if (ovalid) begin
            state <= S_CHECK;  // previous group result not taken yet
          end else if (acc[ACC_B] == '0) begin
            zflag  <= 1'b1;
            res_re <= '0;
            res_im <= '0;
            ovalid <= 1'b1;
            state  <= S_IDLE;
          end else begin
            zflag <= 1'b0;
            comp  <= 1'b0;
            step  <= '0;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (step == STEP_W'(FIN_LAST)) state <= S_DSTART;
          else                           step  <= step + 1'b1;
        end
        S_DSTART: begin
          sn_r  <= nacc[NW-1];
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            if (!comp) begin
              res_re <= sres;
              comp   <= 1'b1;
              step   <= '0;
              state  <= S_FIN;
            end else begin
              res_im <= sres;
              ovalid <= 1'b1;
              state  <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    out_chan.valid && out_chan.zero_energy |->
      out_chan.deriv_re == '0 && out_chan.deriv_im == '0)
    else $error("zero_energy result with nonzero derivative");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> bb != '0)
    else $error("divider started with zero b*b");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_chan.valid && !out_chan.ready |=>
      out_chan.valid && $stable(out_chan.deriv_re) && $stable(out_chan.deriv_im) &&
      $stable(out_chan.zero_energy))
    else $error("pending result changed before it was taken");

  a_clear_after_group: assert property (@(posedge clk) disable iff (rst)
    state == S_DWAIT && div_done && comp |=> acc[ACC_B] == '0)
    else $error("sums not cleared after group result");
`endif
endmodule
